// File: hdl/bitmap_block_allocator_unit_assert.svh
// Assertion macros for the bitmap block allocator.
// Included by the top level; no other dependencies.
`ifndef BITMAP_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH
`define BITMAP_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH
`ifndef SYNTH
`define BBA_ASSERT_DIS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define BBA_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BBA_ASSERT_DIS(label, clk, rst, prop, msg)
`define BBA_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// File: hdl/bba_pkg.sv
// Shared types and constants for the bitmap block allocator.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
package bba_pkg;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_LOAD  = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;

  localparam logic [7:0]  BYTE_FULL         = 8'hff;
  localparam logic [7:0]  BIT_LSB           = 8'h01;
  localparam logic [12:0] BLOCK_COUNT_RESET = 13'd4096;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [11:0] block_index;
    logic [8:0]  byte_address;
    logic [7:0]  map_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] allocated_index;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic clear_step;
    logic free_rd;
    logic free_wr;
    logic scan_adv;
    logic scan_eval;
    logic out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic start_scan;
    logic start_free;
    logic scan_done;
  } dp_status_t;

endpackage

// File: hdl/bba_datapath.sv
// Datapath of the bitmap block allocator: map memory, scan pointer, result registers.
// Depends on bba_pkg; driven by bba_controller through command and status structs.
`timescale 1ns / 1ps
module bba_datapath #(
  parameter int MAX_BLOCKS = 4096
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [12:0]          cfg_wdata,
  input  bba_pkg::in_item_t    in_data,
  output bba_pkg::out_item_t   out_data,
  input  bba_pkg::ctl_cmd_t    cmd,
  output bba_pkg::dp_status_t  stat
);

  localparam int MAP_BYTES = (MAX_BLOCKS + 7) / 8;
  localparam int AW = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
  localparam int LW = (AW + 4 > 13) ? AW + 4 : 13;
  localparam logic [AW-1:0] LAST = AW'(MAP_BYTES - 1);

  function automatic logic [2:0] lowest_clear(input logic [7:0] v);
    logic [2:0] r;
    r = 3'd7;
    for (int i = 7; i >= 0; i--) begin
      if (!v[i]) begin
        r = 3'(i);
      end
    end
    return r;
  endfunction

  logic [7:0]    mem [MAP_BYTES];
  logic [12:0]   block_count;
  logic [AW-1:0] clr_addr;
  logic [AW-1:0] scan_ptr;
  logic [11:0]   bidx_reg;
  logic [7:0]    rd_data;
  logic [AW-1:0] rd_tag;
  logic [1:0]    res_status;
  logic [11:0]   res_index;

  logic [LW-1:0] lim;
  logic [LW-1:0] in_bidx_ext;
  logic [LW-1:0] in_addr_ext;
  logic [LW-1:0] bidx_ext;
  logic          free_bad;
  logic          load_bad;
  logic          in_bad;
  logic          load_ok;
  logic [AW-1:0] free_addr;
  logic [AW-1:0] rd_addr;
  logic          byte_full;
  logic [2:0]    bit_sel;
  logic [LW-1:0] bno;
  logic          found_ok;
  logic          scan_done;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;

  always_comb begin
    lim = (LW'(block_count) > LW'(MAX_BLOCKS)) ? LW'(MAX_BLOCKS) : LW'(block_count);
    in_bidx_ext = LW'(in_data.block_index);
    in_addr_ext = LW'(in_data.byte_address);
    free_bad = in_bidx_ext >= lim;
    load_bad = in_addr_ext >= LW'(MAP_BYTES);
    in_bad = ((in_data.opcode == bba_pkg::OP_FREE) && free_bad) ||
             ((in_data.opcode == bba_pkg::OP_LOAD) && load_bad);
    load_ok = cmd.capture && (in_data.opcode == bba_pkg::OP_LOAD) && !load_bad;
    bidx_ext = LW'(bidx_reg);
    free_addr = AW'(bidx_ext >> 3);
    rd_addr = cmd.free_rd ? free_addr : scan_ptr;
    byte_full = rd_data == bba_pkg::BYTE_FULL;
    bit_sel = lowest_clear(rd_data);
    bno = LW'({rd_tag, bit_sel});
    found_ok = !byte_full && (bno < lim);
    scan_done = cmd.scan_eval && (!byte_full || (rd_tag == LAST));
  end

  always_comb begin
    wr_en = 1'b0;
    wr_addr = clr_addr;
    wr_data = '0;
    if (cmd.clear_step) begin
      wr_en = 1'b1;
    end else if (load_ok) begin
      wr_en = 1'b1;
      wr_addr = AW'(in_addr_ext);
      wr_data = in_data.map_byte;
    end else if (cmd.free_wr) begin
      wr_en = 1'b1;
      wr_addr = free_addr;
      wr_data = rd_data & ~(bba_pkg::BIT_LSB << bidx_reg[2:0]);
    end else if (scan_done && found_ok) begin
      wr_en = 1'b1;
      wr_addr = rd_tag;
      wr_data = rd_data | (bba_pkg::BIT_LSB << bit_sel);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
    rd_tag <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_count <= bba_pkg::BLOCK_COUNT_RESET;
      clr_addr <= '0;
    end else begin
      if (cfg_we) begin
        block_count <= cfg_wdata;
      end
      if (cmd.clear_step && (clr_addr != LAST)) begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      scan_ptr <= '0;
      bidx_reg <= in_data.block_index;
      res_status <= in_bad ? bba_pkg::ST_RANGE : bba_pkg::ST_OK;
      res_index <= '0;
    end else begin
      if (cmd.scan_adv && (scan_ptr != LAST)) begin
        scan_ptr <= scan_ptr + 1'b1;
      end
      if (scan_done) begin
        res_status <= found_ok ? bba_pkg::ST_OK : bba_pkg::ST_NOSPACE;
        res_index <= found_ok ? 12'(bno) : 12'd0;
      end
    end
    if (cmd.out_load) begin
      out_data.status <= res_status;
      out_data.allocated_index <= res_index;
    end
  end

  always_comb begin
    stat.clear_last = clr_addr == LAST;
    stat.start_scan = in_data.opcode == bba_pkg::OP_ALLOC;
    stat.start_free = (in_data.opcode == bba_pkg::OP_FREE) && !free_bad;
    stat.scan_done = scan_done;
  end

endmodule

// File: hdl/bba_controller.sv
// Controller state machine of the bitmap block allocator.
// Depends on bba_pkg; drives bba_datapath with commands and reads its status.
`timescale 1ns / 1ps
module bba_controller (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output bba_pkg::ctl_cmd_t    cmd,
  input  bba_pkg::dp_status_t  stat
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_FREE_RD,
    S_FREE_WR,
    S_SCAN_ISSUE,
    S_SCAN,
    S_FINISH
  } state_t;

  state_t state;
  logic   accept;
  logic   slot_free;

  always_comb begin
    in_ready = state == S_IDLE;
    accept = in_valid && in_ready;
    slot_free = !out_valid || out_ready;
    cmd.capture = accept;
    cmd.clear_step = state == S_CLEAR;
    cmd.free_rd = state == S_FREE_RD;
    cmd.free_wr = state == S_FREE_WR;
    cmd.scan_adv = (state == S_SCAN_ISSUE) || (state == S_SCAN);
    cmd.scan_eval = state == S_SCAN;
    cmd.out_load = (state == S_FINISH) && slot_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          if (stat.clear_last) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            if (stat.start_scan) begin
              state <= S_SCAN_ISSUE;
            end else if (stat.start_free) begin
              state <= S_FREE_RD;
            end else begin
              state <= S_FINISH;
            end
          end
        end
        S_FREE_RD: state <= S_FREE_WR;
        S_FREE_WR: state <= S_FINISH;
        S_SCAN_ISSUE: state <= S_SCAN;
        S_SCAN: begin
          if (stat.scan_done) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

endmodule

// File: hdl/bitmap_block_allocator_unit.sv
// Top level of the first-fit bitmap block allocator.
// Depends on bba_pkg, bba_controller, bba_datapath and the assertion header.
//
// Usage: requests enter on in_valid/in_ready as one in_data transaction (allocate,
// free or load of one map byte); each request yields exactly one out_data
// transaction on out_valid/out_ready carrying a status and the granted index.
// The block count register is written through cfg_we/cfg_wdata; the user must
// write it only while idle, which the block itself does not check.
// A load, an unused opcode or a rejected request goes straight to the result;
// a free reads and rewrites one map byte; an allocate scans through the single
// memory read port, one map byte per cycle, to the first non-full or last byte.
// One request is in progress at a time; in_ready is high only when idle.
// After reset the map memory is cleared one byte per cycle, with in_ready low,
// and the block count returns to 4096.
// A finished result waits in an output register; in_ready returns while it
// waits, but the next result stays in the block until the receiver takes it.
`timescale 1ns / 1ps
`include "bitmap_block_allocator_unit_assert.svh"
module bitmap_block_allocator_unit #(
  parameter int MAX_BLOCKS = 4096
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [12:0]         cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  bba_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output bba_pkg::out_item_t  out_data
);

  bba_pkg::ctl_cmd_t   cmd;
  bba_pkg::dp_status_t stat;

  bba_controller u_ctl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  bba_datapath #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .out_data  (out_data),
    .cmd       (cmd),
    .stat      (stat)
  );

  `BBA_ASSERT_DIS(a_busy_after_accept, clk, rst, (in_valid && in_ready) |=> !in_ready, "ready high right after a transaction was accepted")
  `BBA_ASSERT_ALWAYS(a_clear_after_reset, clk, $fell(rst) |-> !in_ready, "input accepted before the map clear finished")
  `BBA_ASSERT_DIS(a_index_zero_on_error, clk, rst, (out_valid && (out_data.status != bba_pkg::ST_OK)) |-> (out_data.allocated_index == 12'd0), "nonzero index with error status")

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for bitmap_block_allocator_unit, the first-fit block allocator.
// It depends on bba_pkg and on the RTL of the block. A model of the free map predicts
// every reply, and both handshake sides idle and stall at random.
`timescale 1ns / 1ps
module tb_top;

  localparam int MAX_BLOCKS = 4096;
  localparam int MAP_BYTES = (MAX_BLOCKS + 7) / 8;
  localparam int CYCLE_LIMIT = 3000000;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_we = 1'b0;
  logic [12:0]         cfg_wdata = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  bba_pkg::in_item_t   in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  bba_pkg::out_item_t  out_data;

  bitmap_block_allocator_unit #(.MAX_BLOCKS(MAX_BLOCKS)) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  bba_pkg::in_item_t   request_queue[$];
  bba_pkg::out_item_t  owed_replies[$];
  logic [7:0]  map_bytes [MAP_BYTES];
  logic [12:0] managed_blocks = bba_pkg::BLOCK_COUNT_RESET;

  bit          in_taken = 1'b0;
  bit          out_taken = 1'b0;
  bit          quiet = 1'b0;
  int unsigned send_gap = 0;
  int unsigned hold_left = 0;
  int          n_queued = 0;
  int          n_accepted = 0;
  int          n_replies = 0;
  int          n_errors = 0;
  int          n_granted = 0;
  int          n_nospace = 0;
  int          n_range = 0;
  int          n_settings = 0;
  int          cycle_cnt = 0;

  always #1 clk = ~clk;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic bba_pkg::out_item_t apply_to_map(bba_pkg::in_item_t req);
    bba_pkg::out_item_t res;
    int unsigned lim;
    int unsigned a;
    int unsigned b;
    bit          found;
    res.status = bba_pkg::ST_OK;
    res.allocated_index = '0;
    lim = (managed_blocks > MAX_BLOCKS) ? MAX_BLOCKS : managed_blocks;
    case (req.opcode)
      bba_pkg::OP_ALLOC: begin
        res.status = bba_pkg::ST_NOSPACE;
        found = 1'b0;
        for (a = 0; a < MAP_BYTES && !found; a++) begin
          if (map_bytes[a] != bba_pkg::BYTE_FULL) begin
            found = 1'b1;
            b = 0;
            while (b < 7 && map_bytes[a][b]) b++;
            if (a * 8 + b < lim) begin
              map_bytes[a][b] = 1'b1;
              res.status = bba_pkg::ST_OK;
              res.allocated_index = 12'(a * 8 + b);
            end
          end
        end
      end
      bba_pkg::OP_FREE: begin
        if (req.block_index >= lim) res.status = bba_pkg::ST_RANGE;
        else map_bytes[req.block_index[11:3]][req.block_index[2:0]] = 1'b0;
      end
      bba_pkg::OP_LOAD: begin
        if (req.byte_address >= MAP_BYTES) res.status = bba_pkg::ST_RANGE;
        else map_bytes[req.byte_address] = req.map_byte;
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    if (n_errors < 40)
      $display("MISMATCH at cycle %0d, reply %0d: %s got %0d, expected %0d",
               cycle_cnt, n_replies, what, got, want);
    n_errors++;
  endtask

  // Requests change at the falling edge and hold until the rising edge accepts them.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
    end else if (send_gap != 0) begin
      in_valid <= 1'b0;
      send_gap <= send_gap - 1;
    end else if (request_queue.size() != 0) begin
      in_data <= request_queue.pop_front();
      in_valid <= 1'b1;
      send_gap <= pick_gap();
    end else begin
      in_valid <= 1'b0;
    end
  end

  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ready <= 1'b1;
      if (out_taken) hold_left <= pick_gap();
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    in_taken <= in_valid && in_ready && !rst;
    out_taken <= out_valid && out_ready && !rst;
  end

  always @(posedge clk) begin
    bba_pkg::out_item_t want;
    if (rst) begin
      foreach (map_bytes[i]) map_bytes[i] = '0;
      managed_blocks = bba_pkg::BLOCK_COUNT_RESET;
    end else begin
      if (cfg_we) managed_blocks = cfg_wdata;
      if (in_valid && in_ready) begin
        want = apply_to_map(in_data);
        owed_replies.push_back(want);
        n_accepted++;
        if (want.status == bba_pkg::ST_OK && in_data.opcode == bba_pkg::OP_ALLOC)
          n_granted++;
        if (want.status == bba_pkg::ST_NOSPACE) n_nospace++;
        if (want.status == bba_pkg::ST_RANGE) n_range++;
      end
      if (out_valid && out_ready) begin
        if (owed_replies.size() == 0) begin
          report_mismatch("unexpected transaction, status", out_data.status, -1);
        end else begin
          want = owed_replies.pop_front();
          if (out_data.status !== want.status)
            report_mismatch("status", out_data.status, want.status);
          if (out_data.allocated_index !== want.allocated_index)
            report_mismatch("allocated_index", out_data.allocated_index,
                            want.allocated_index);
        end
        n_replies++;
      end
    end
  end

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("Timeout with %0d replies still owed", owed_replies.size());
    $display("bitmap_block_allocator_unit test failed");
    $finish;
  end

  function automatic bba_pkg::in_item_t make_item(logic [1:0] op, logic [11:0] bidx,
                                                  logic [8:0] addr, logic [7:0] mbyte);
    bba_pkg::in_item_t it;
    it.opcode = op;
    it.block_index = bidx;
    it.byte_address = addr;
    it.map_byte = mbyte;
    return it;
  endfunction

  task automatic queue_item(bba_pkg::in_item_t it);
    request_queue.push_back(it);
    n_queued++;
  endtask

  task automatic queue_random(int n, int unsigned lim);
    bba_pkg::in_item_t it;
    int unsigned       r;
    repeat (n) begin
      it = make_item(2'($urandom), 12'($urandom), 9'($urandom), 8'($urandom));
      r = $urandom_range(0, 99);
      if (r < 45) begin
        it.opcode = bba_pkg::OP_ALLOC;
      end else if (r < 75) begin
        it.opcode = bba_pkg::OP_FREE;
        r = $urandom_range(0, 99);
        if (r < 60) it.block_index = 12'($urandom_range(0, 63));
        else if (r < 85 && lim > 0) it.block_index = 12'($urandom_range(0, lim - 1));
      end else if (r < 93) begin
        it.opcode = bba_pkg::OP_LOAD;
        if ($urandom_range(0, 9) < 7) it.byte_address = 9'($urandom_range(0, 15));
        r = $urandom_range(0, 9);
        if (r < 3) it.map_byte = bba_pkg::BYTE_FULL;
        else if (r < 5) it.map_byte = '0;
      end else begin
        it.opcode = OP_UNUSED;
      end
      queue_item(it);
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (n_accepted != n_queued || owed_replies.size() != 0);
  endtask

  task automatic write_block_count(logic [12:0] v);
    wait_drained();
    cfg_wdata <= v;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    quiet <= ($urandom_range(0, 3) == 0);
    n_settings++;
  endtask

  initial begin
    int unsigned cnt;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    queue_item(make_item(bba_pkg::OP_ALLOC, 12'd0, 9'd0, 8'd0));
    queue_item(make_item(bba_pkg::OP_ALLOC, 12'hfff, 9'h1ff, 8'hff));
    queue_item(make_item(bba_pkg::OP_FREE, 12'd0, 9'd0, 8'd0));
    queue_item(make_item(bba_pkg::OP_FREE, 12'd0, 9'd0, 8'd0));
    queue_item(make_item(bba_pkg::OP_ALLOC, 12'd0, 9'd0, 8'd0));
    queue_item(make_item(OP_UNUSED, 12'hfff, 9'h1ff, 8'hff));
    queue_item(make_item(bba_pkg::OP_FREE, 12'd4095, 9'd0, 8'd0));
    queue_item(make_item(bba_pkg::OP_LOAD, 12'd0, 9'd511, bba_pkg::BYTE_FULL));
    queue_item(make_item(bba_pkg::OP_LOAD, 12'd0, 9'd0, 8'h7f));
    queue_item(make_item(bba_pkg::OP_ALLOC, 12'd0, 9'd0, 8'd0));
    queue_item(make_item(bba_pkg::OP_LOAD, 12'd0, 9'd0, 8'h00));
    queue_item(make_item(bba_pkg::OP_LOAD, 12'd0, 9'd1, 8'h55));
    queue_item(make_item(bba_pkg::OP_FREE, 12'd9, 9'd0, 8'd0));
    queue_item(make_item(bba_pkg::OP_ALLOC, 12'd0, 9'd0, 8'd0));
    queue_random(60, 4096);

    // A single managed block: the second allocation runs past the count.
    write_block_count(13'd1);
    queue_item(make_item(bba_pkg::OP_LOAD, 12'd0, 9'd0, 8'h00));
    queue_item(make_item(bba_pkg::OP_ALLOC, 12'd0, 9'd0, 8'd0));
    queue_item(make_item(bba_pkg::OP_ALLOC, 12'd0, 9'd0, 8'd0));
    queue_item(make_item(bba_pkg::OP_FREE, 12'd1, 9'd0, 8'd0));
    queue_item(make_item(bba_pkg::OP_FREE, 12'd0, 9'd0, 8'd0));
    queue_random(60, 1);

    write_block_count(13'd0);
    queue_item(make_item(bba_pkg::OP_ALLOC, 12'd0, 9'd0, 8'd0));
    queue_item(make_item(bba_pkg::OP_FREE, 12'd0, 9'd0, 8'd0));
    queue_random(40, 0);

    write_block_count(13'd37);
    queue_random(120, 37);

    cnt = $urandom_range(2, 4096);
    write_block_count(13'(cnt));
    queue_random(120, cnt);

    cnt = $urandom_range(1, 300);
    write_block_count(13'(cnt));
    queue_random(120, cnt);

    // A count above the map size is clamped; fill the map so the scan reaches the last byte.
    write_block_count(13'h1fff);
    for (int a = 0; a < MAP_BYTES - 1; a++)
      queue_item(make_item(bba_pkg::OP_LOAD, 12'($urandom), 9'(a), bba_pkg::BYTE_FULL));
    queue_item(make_item(bba_pkg::OP_LOAD, 12'd0, 9'(MAP_BYTES - 1), 8'h7f));
    queue_item(make_item(bba_pkg::OP_ALLOC, 12'd0, 9'd0, 8'd0));
    queue_item(make_item(bba_pkg::OP_ALLOC, 12'd0, 9'd0, 8'd0));
    queue_item(make_item(bba_pkg::OP_FREE, 12'd4095, 9'd0, 8'd0));
    queue_item(make_item(bba_pkg::OP_ALLOC, 12'd0, 9'd0, 8'd0));
    queue_item(make_item(bba_pkg::OP_FREE, 12'd100, 9'd0, 8'd0));
    queue_item(make_item(bba_pkg::OP_ALLOC, 12'd0, 9'd0, 8'd0));

    write_block_count(13'd4096);
    queue_random(100, 4096);

    wait_drained();
    repeat (520) @(negedge clk);
    $display("Covered %0d requests and %0d replies under %0d block count settings.",
             n_accepted, n_replies, n_settings);
    $display("Replies: %0d blocks granted, %0d no space, %0d out of range, %0d mismatches.",
             n_granted, n_nospace, n_range, n_errors);
    if (n_errors == 0) begin
      $display("bitmap_block_allocator_unit test passed");
    end else begin
      $display("bitmap_block_allocator_unit test failed");
    end
    $finish;
  end

endmodule
